// ===== rtl/json_string_unescaper_core_defines.svh =====
// Assertion macros shared by the unescaper RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef JSON_STRING_UNESCAPER_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define JSU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jsu assertion failed");
`define JSU_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("jsu forbidden condition");
`else
`define JSU_ASSERT(label, clk, rst_n, prop)
`define JSU_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/jsu_pkg.sv =====
// Types, byte codes and decode functions for the JSON string unescaper.
// No dependencies.
package jsu_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] CP_ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_BYTE_LIMIT = 16'h0800;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_req;
        logic       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic       unterminated;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [2:0][7:0] data_bytes;
        logic [1:0]      nbytes;
        logic            done;
        logic            unterm;
    } t_job;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
        return v;
    endfunction

    // Returns {hit, mapped byte}.
    function automatic logic [8:0] escape_map(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            CH_QUOTE:     r = {1'b1, 8'h22};
            CH_BACKSLASH: r = {1'b1, 8'h5C};
            CH_SLASH:     r = {1'b1, 8'h2F};
            CH_LOWER_N:   r = {1'b1, 8'h0A};
            CH_LOWER_T:   r = {1'b1, 8'h09};
            CH_LOWER_R:   r = {1'b1, 8'h0D};
            CH_LOWER_B:   r = {1'b1, 8'h08};
            CH_LOWER_F:   r = {1'b1, 8'h0C};
            default:      r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/jsu_front.sv =====
// Parser front end: accepts input bytes and turns each into at most one queue job.
// Depends on jsu_pkg.
module jsu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  jsu_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_push,
    output jsu_pkg::t_job     o_job
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } t_mode;

    t_mode           r_mode, n_mode;
    logic [1:0]      r_cnt, n_cnt;
    logic [15:0]     r_acc, n_acc;
    logic [7:0]      r_held [3];
    logic            held_we;
    logic            accept;
    logic [7:0]      b;
    logic [15:0]     acc_sh;
    logic [8:0]      esc;
    t_job            job;

    assign accept = i_in_valid && !i_q_full;
    assign b      = i_in_item.in_byte;
    assign acc_sh = {r_acc[11:0], hex_value(b)};
    assign esc    = escape_map(b);

    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        held_we = 1'b0;
        job     = '0;
        if (accept) begin
            unique case (r_mode)
                MODE_IDLE: begin
                    if (i_in_item.start_req) n_mode = MODE_STR;
                end
                MODE_STR: begin
                    if (b == CH_QUOTE) begin
                        job.done = 1'b1;
                        n_mode   = MODE_IDLE;
                    end else if (b == CH_BACKSLASH) begin
                        if (i_in_item.buffer_end) begin
                            job.data_bytes[0] = b;
                            job.nbytes        = 2'd1;
                        end else begin
                            n_mode = MODE_ESC;
                        end
                    end else begin
                        job.data_bytes[0] = b;
                        job.nbytes        = 2'd1;
                    end
                end
                MODE_ESC: begin
                    if (b == CH_LOWER_U) begin
                        n_mode = i_in_item.buffer_end ? MODE_STR : MODE_HEX;
                        n_cnt  = 2'd0;
                        n_acc  = 16'd0;
                    end else begin
                        if (esc[8]) begin
                            job.data_bytes[0] = esc[7:0];
                            job.nbytes        = 2'd1;
                        end
                        n_mode = MODE_STR;
                    end
                end
                MODE_HEX: begin
                    n_acc = acc_sh;
                    if (r_cnt == 2'd3) begin
                        if (acc_sh < CP_ONE_BYTE_LIMIT) begin
                            job.data_bytes[0] = acc_sh[7:0];
                            job.nbytes        = 2'd1;
                        end else if (acc_sh < CP_TWO_BYTE_LIMIT) begin
                            job.data_bytes[0] = UTF8_LEAD2 | {3'd0, acc_sh[10:6]};
                            job.data_bytes[1] = UTF8_CONT | {2'd0, acc_sh[5:0]};
                            job.nbytes        = 2'd2;
                        end else begin
                            job.data_bytes[0] = UTF8_LEAD3 | {4'd0, acc_sh[15:12]};
                            job.data_bytes[1] = UTF8_CONT | {2'd0, acc_sh[11:6]};
                            job.data_bytes[2] = UTF8_CONT | {2'd0, acc_sh[5:0]};
                            job.nbytes        = 2'd3;
                        end
                        n_cnt  = 2'd0;
                        n_mode = MODE_STR;
                    end else if (i_in_item.buffer_end) begin
                        // flush gathered digits raw, then this byte
                        job.data_bytes[0] = (r_cnt > 2'd0) ? r_held[0] : b;
                        job.data_bytes[1] = (r_cnt > 2'd1) ? r_held[1] : b;
                        job.data_bytes[2] = b;
                        job.nbytes        = 2'(r_cnt + 2'd1);
                        n_cnt             = 2'd0;
                        n_mode            = MODE_STR;
                    end else begin
                        held_we = 1'b1;
                        n_cnt   = 2'(r_cnt + 2'd1);
                    end
                end
                default: n_mode = MODE_IDLE;
            endcase
            if (i_in_item.buffer_end && n_mode != MODE_IDLE) begin
                job.done   = 1'b1;
                job.unterm = 1'b1;
                n_mode     = MODE_IDLE;
                n_cnt      = 2'd0;
            end
        end
    end

    assign o_push = accept && (job.nbytes != 2'd0 || job.done);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_cnt  <= 2'd0;
            r_acc  <= 16'd0;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (held_we) r_held[r_cnt] <= b;
    end

endmodule

// ===== rtl/jsu_queue.sv =====
// Job queue between parser front end and output back end.
// Depends on jsu_pkg and json_string_unescaper_core_defines.svh.
`include "json_string_unescaper_core_defines.svh"
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output jsu_pkg::t_job o_head
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_LAST) ? '0 : PTR_W'(r_wr + 1'b1);
            if (i_pop)  r_rd <= (r_rd == PTR_LAST) ? '0 : PTR_W'(r_rd + 1'b1);
            if (i_push && !i_pop)      r_cnt <= CNT_W'(r_cnt + 1'b1);
            else if (i_pop && !i_push) r_cnt <= CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    `JSU_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full)
    `JSU_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && o_empty)
    `JSU_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CNT_FULL)

endmodule

// ===== rtl/jsu_back.sv =====
// Output back end: walks the head job and sends one result per transfer.
// Depends on jsu_pkg and json_string_unescaper_core_defines.svh.
`include "json_string_unescaper_core_defines.svh"
module jsu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  jsu_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jsu_pkg::t_out_item o_out_item
);
    import jsu_pkg::*;

    logic [1:0] r_idx;
    logic [1:0] last_idx;
    logic       fin;
    logic       load;
    logic       has_byte;
    t_out_item  r_out, n_out;
    logic       r_out_valid;

    assign last_idx = (i_head.nbytes == 2'd0) ? 2'd0 : 2'(i_head.nbytes - 2'd1);
    assign fin      = (r_idx == last_idx);
    assign load     = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign has_byte = (r_idx < i_head.nbytes);
    assign o_pop    = load && fin;

    always_comb begin
        n_out              = '0;
        n_out.out_byte     = has_byte ? i_head.data_bytes[r_idx] : 8'd0;
        n_out.byte_valid   = has_byte;
        n_out.string_done  = fin && i_head.done;
        n_out.unterminated = fin && i_head.unterm;
        n_out.last         = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_idx       <= fin ? 2'd0 : 2'(r_idx + 2'd1);
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `JSU_ASSERT(a_partial_has_head, i_clk, i_rst_n, (r_idx != 2'd0) |-> !i_q_empty)
    `JSU_ASSERT(a_done_on_last, i_clk, i_rst_n, (r_out_valid && r_out.string_done) |-> r_out.last)
    `JSU_ASSERT(a_empty_is_final, i_clk, i_rst_n, (r_out_valid && !r_out.byte_valid) |-> r_out.last)

endmodule

// ===== rtl/json_string_unescaper_core.sv =====
// JSON string unescaper, one input byte per cycle while the queue is not
// full. Each accepted byte is parsed at once and becomes at most one queue
// job of zero to three output bytes; the back end drains jobs at one
// result per cycle through its output register while the output is not
// stalled. Plain bytes and simple escapes give one result, so the block
// runs at one byte per cycle unless stalled; a \u completion (or a buffer
// end during \u) gives up to three results, with QUEUE_DEPTH jobs of slack
// before the input stalls. No clearing pass after reset.
module json_string_unescaper_core #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jsu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jsu_pkg::t_out_item o_out_item
);
    import jsu_pkg::*;

    logic q_full, q_empty, push, pop;
    t_job job, head;

    assign o_in_stall = q_full;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
